[rtl/core/hkd_pkg.sv]
// ----------------------------------------------------------------------------
// hkd_pkg
// Shared widths, register indexes and configuration types for the heatmap
// keypoint decoder.
// ----------------------------------------------------------------------------
package hkd_pkg;

	localparam int MAX_MAP_DIM_DEF = 256;

	localparam int BOX_W      = 12;
	localparam int DIM_CFG_W  = 9;
	localparam int ASP_W      = 16;
	localparam int SAMPLE_W   = 16;
	localparam int PEAK_W     = 15;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// internal fixed point: 16 fraction bits
	localparam int FRAC_BITS = 16;
	localparam int DIV_W     = 40;
	localparam int ACC_W     = 50;

	localparam logic [CFG_IDX_W-1:0] REG_BOX_LEFT     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_TOP      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_RIGHT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_BOTTOM   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ASPECT       = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_USE_UDP      = 3'd7;

	typedef struct packed {
		logic [BOX_W-1:0] box_left;
		logic [BOX_W-1:0] box_top;
		logic [BOX_W-1:0] box_right;
		logic [BOX_W-1:0] box_bottom;
		logic [ASP_W-1:0] aspect;
		logic             use_udp;
	} box_cfg_t;

endpackage

[rtl/core/hkd_front.sv]
// ----------------------------------------------------------------------------
// hkd_front
// Sample intake: running maximum with its column and row, raster counters,
// and a push of the finished peak when the last sample of a map arrives.
// ----------------------------------------------------------------------------
module hkd_front import hkd_pkg::*; #(
	parameter int CW = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [CW:0]                eff_w,
	input  logic [CW:0]                eff_h,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample_value,
	input  logic                       q_full,
	output logic                       push,
	output logic signed [SAMPLE_W-1:0] push_value,
	output logic [CW-1:0]              push_col,
	output logic [CW-1:0]              push_row
);

	logic signed [SAMPLE_W-1:0] best_q;
	logic [CW-1:0]              best_col_q;
	logic [CW-1:0]              best_row_q;
	logic [CW-1:0]              col_q;
	logic [CW-1:0]              row_q;
	logic                       acc;
	logic                       take;
	logic                       col_last;
	logic                       row_last;

	assign in_stall = q_full;
	assign acc      = in_valid && !q_full;

	// first sample of a map always wins; ties keep the earlier one
	assign take     = ((col_q == '0) && (row_q == '0)) || (sample_value > best_q);
	assign col_last = ({1'b0, col_q} + (CW+1)'(1)) >= eff_w;
	assign row_last = ({1'b0, row_q} + (CW+1)'(1)) >= eff_h;

	assign push       = acc && col_last && row_last;
	assign push_value = take ? sample_value : best_q;
	assign push_col   = take ? col_q : best_col_q;
	assign push_row   = take ? row_q : best_row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q     <= '0;
			best_col_q <= '0;
			best_row_q <= '0;
			col_q      <= '0;
			row_q      <= '0;
		end else if (acc) begin
			best_q     <= push_value;
			best_col_q <= push_col;
			best_row_q <= push_row;
			if (col_last) begin
				col_q <= '0;
				if (row_last) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + CW'(1);
				end
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

endmodule

[rtl/core/hkd_queue.sv]
// ----------------------------------------------------------------------------
// hkd_queue
// Two-entry register queue between the sample front and the transform back.
// ----------------------------------------------------------------------------
module hkd_queue import hkd_pkg::*; #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty,
	output logic         full
);

	logic [W-1:0] slot_q [2];
	logic         wp_q;
	logic         rp_q;
	logic [1:0]   cnt_q;

	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign dout  = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[rtl/core/hkd_div.sv]
// ----------------------------------------------------------------------------
// hkd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hkd_div import hkd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [15:0]      divisor,
	output logic             done,
	output logic [DIV_W-1:0] quo
);

	localparam int CNT_W = $clog2(DIV_W);

	logic [15:0]      rem_q;
	logic [15:0]      dvs_q;
	logic [DIV_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [16:0]      trial;
	logic             fits;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign done  = done_q;
	assign quo   = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? 16'(trial - {1'b0, dvs_q}) : trial[15:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

[rtl/core/hkd_back.sv]
// ----------------------------------------------------------------------------
// hkd_back
// Box transform sequencer: aspect fit, 1.25 scale, per-axis step division,
// shift-add position multiply, truncation and saturation into the output word.
// ----------------------------------------------------------------------------
module hkd_back import hkd_pkg::*; #(
	parameter int CW = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  box_cfg_t                   cfg,
	input  logic [CW:0]                eff_w,
	input  logic [CW:0]                eff_h,
	input  logic                       q_empty,
	input  logic signed [SAMPLE_W-1:0] q_value,
	input  logic [CW-1:0]              q_col,
	input  logic [CW-1:0]              q_row,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [PEAK_W-1:0]   peak_x,
	output logic signed [PEAK_W-1:0]   peak_y,
	output logic signed [SAMPLE_W-1:0] peak_score,
	output logic                       found
);

	localparam int CNT_W = $clog2(CW + 1);
	localparam int Q_W   = ACC_W - FRAC_BITS;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CMP   = 4'd1;
	localparam logic [3:0] ST_SIZE  = 4'd2;
	localparam logic [3:0] ST_DIVH  = 4'd3;
	localparam logic [3:0] ST_SCALE = 4'd4;
	localparam logic [3:0] ST_STX   = 4'd5;
	localparam logic [3:0] ST_DIVX  = 4'd6;
	localparam logic [3:0] ST_STY   = 4'd7;
	localparam logic [3:0] ST_DIVY  = 4'd8;
	localparam logic [3:0] ST_MUL   = 4'd9;
	localparam logic [3:0] ST_SUM   = 4'd10;
	localparam logic [3:0] ST_OUT   = 4'd11;

	logic [3:0]                 state_q;
	logic signed [SAMPLE_W-1:0] val_q;
	logic [CW-1:0]              posx_q;
	logic [CW-1:0]              posy_q;
	logic                       found_q;
	logic signed [12:0]         w_q;
	logic signed [12:0]         h_q;
	logic signed [29:0]         prod_q;
	logic signed [DIV_W-1:0]    wq_q;
	logic signed [DIV_W-1:0]    hq_q;
	logic                       hneg_q;
	logic [DIV_W-1:0]           sx_mag_q;
	logic [DIV_W-1:0]           sy_mag_q;
	logic                       sx_neg_q;
	logic                       sy_neg_q;
	logic signed [ACC_W-1:0]    stx_q;
	logic signed [ACC_W-1:0]    sty_q;
	logic signed [ACC_W-1:0]    accx_q;
	logic signed [ACC_W-1:0]    accy_q;
	logic signed [ACC_W-1:0]    cx_q;
	logic signed [ACC_W-1:0]    cy_q;
	logic [CNT_W-1:0]           cnt_q;

	logic                       out_valid_q;
	logic signed [PEAK_W-1:0]   peak_x_q;
	logic signed [PEAK_W-1:0]   peak_y_q;
	logic signed [SAMPLE_W-1:0] peak_score_q;
	logic                       found_out_q;

	logic [ASP_W-1:0]           a_eff;
	logic signed [16:0]         a_s;
	logic signed [29:0]         w256;
	logic [11:0]                wabs;
	logic [DIV_W-1:0]           wq_mag;
	logic [DIV_W-1:0]           hq_mag;
	logic [DIV_W+1:0]           sx5;
	logic [DIV_W+1:0]           sy5;
	logic [CW:0]                dx;
	logic [CW:0]                dy;
	logic                       div_start;
	logic [DIV_W-1:0]           div_a;
	logic [15:0]                div_b;
	logic                       div_done;
	logic [DIV_W-1:0]           div_q;
	logic signed [ACC_W-1:0]    step;
	logic signed [ACC_W-1:0]    centre_x;
	logic signed [ACC_W-1:0]    centre_y;
	logic signed [ACC_W-1:0]    half_x;
	logic signed [ACC_W-1:0]    half_y;
	logic signed [Q_W-1:0]      qx;
	logic signed [Q_W-1:0]      qy;
	logic signed [PEAK_W-1:0]   sat_x;
	logic signed [PEAK_W-1:0]   sat_y;
	logic                       out_free;

	function automatic logic signed [Q_W-1:0] to_pixel(input logic signed [ACC_W-1:0] c);
		logic signed [ACC_W-1:0] t;
		t = c[ACC_W-1] ? c + ACC_W'((1 << FRAC_BITS) - 1) : c;
		return Q_W'(t >>> FRAC_BITS);
	endfunction

	function automatic logic signed [PEAK_W-1:0] sat_peak(input logic signed [Q_W-1:0] v);
		logic signed [Q_W-1:0] lo;
		logic signed [Q_W-1:0] hi;
		lo = -Q_W'(1 << (PEAK_W - 1));
		hi = Q_W'((1 << (PEAK_W - 1)) - 1);
		if (v < lo) begin
			return lo[PEAK_W-1:0];
		end else if (v > hi) begin
			return hi[PEAK_W-1:0];
		end
		return v[PEAK_W-1:0];
	endfunction

	assign a_eff  = (cfg.aspect == '0) ? ASP_W'(1) : cfg.aspect;
	assign a_s    = {1'b0, a_eff};
	assign w256   = {{9{w_q[12]}}, w_q, 8'b0};
	assign wabs   = 12'(w_q[12] ? -w_q : w_q);
	assign wq_mag = wq_q[DIV_W-1] ? DIV_W'(-wq_q) : DIV_W'(wq_q);
	assign hq_mag = hq_q[DIV_W-1] ? DIV_W'(-hq_q) : DIV_W'(hq_q);
	assign sx5    = {wq_mag, 2'b0} + {2'b0, wq_mag};
	assign sy5    = {hq_mag, 2'b0} + {2'b0, hq_mag};
	assign dx     = cfg.use_udp ? eff_w - (CW+1)'(1) : eff_w;
	assign dy     = cfg.use_udp ? eff_h - (CW+1)'(1) : eff_h;

	always_comb begin
		div_start = 1'b0;
		div_a     = {16'b0, sx_mag_q[DIV_W-1:16]};
		div_b     = 16'(dx);
		case (state_q)
			ST_SIZE: begin
				div_start = w256 > prod_q;
				div_a     = {4'b0, wabs, 24'b0};
				div_b     = a_eff;
			end
			ST_STX: begin
				div_start = 1'b1;
				div_a     = sx_mag_q;
				div_b     = 16'(dx);
			end
			ST_STY: begin
				div_start = 1'b1;
				div_a     = sy_mag_q;
				div_b     = 16'(dy);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	hkd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quo      (div_q)
	);

	// step carries the sign of the scaled size
	assign step = ((state_q == ST_DIVX) ? sx_neg_q : sy_neg_q)
		? -$signed({{(ACC_W-DIV_W){1'b0}}, div_q})
		: $signed({{(ACC_W-DIV_W){1'b0}}, div_q});

	assign centre_x = $signed({{(ACC_W-BOX_W-16){1'b0}},
		{1'b0, cfg.box_left} + {1'b0, cfg.box_right}, 15'b0});
	assign centre_y = $signed({{(ACC_W-BOX_W-16){1'b0}},
		{1'b0, cfg.box_top} + {1'b0, cfg.box_bottom}, 15'b0});
	assign half_x = sx_neg_q
		? -$signed({{(ACC_W-DIV_W+1){1'b0}}, sx_mag_q[DIV_W-1:1]})
		: $signed({{(ACC_W-DIV_W+1){1'b0}}, sx_mag_q[DIV_W-1:1]});
	assign half_y = sy_neg_q
		? -$signed({{(ACC_W-DIV_W+1){1'b0}}, sy_mag_q[DIV_W-1:1]})
		: $signed({{(ACC_W-DIV_W+1){1'b0}}, sy_mag_q[DIV_W-1:1]});

	assign qx    = to_pixel(cx_q);
	assign qy    = to_pixel(cy_q);
	assign sat_x = sat_peak(qx);
	assign sat_y = sat_peak(qy);

	assign out_free = !out_valid_q || !out_stall;
	assign pop      = (state_q == ST_IDLE) && !q_empty;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				val_q   <= q_value;
				posx_q  <= q_col;
				posy_q  <= q_row;
				found_q <= !q_value[SAMPLE_W-1] && (q_value != '0);
				w_q     <= $signed({1'b0, cfg.box_right} - {1'b0, cfg.box_left});
				h_q     <= $signed({1'b0, cfg.box_bottom} - {1'b0, cfg.box_top});
			end
			ST_CMP: begin
				prod_q <= a_s * h_q;
			end
			ST_SIZE: begin
				if (w256 > prod_q) begin
					wq_q   <= {{11{w_q[12]}}, w_q, 16'b0};
					hneg_q <= w_q[12];
				end else if (w256 < prod_q) begin
					hq_q <= {{11{h_q[12]}}, h_q, 16'b0};
					wq_q <= {{2{prod_q[29]}}, prod_q, 8'b0};
				end else begin
					wq_q <= {{11{w_q[12]}}, w_q, 16'b0};
					hq_q <= {{11{h_q[12]}}, h_q, 16'b0};
				end
			end
			ST_DIVH: begin
				if (div_done) begin
					hq_q <= hneg_q ? -$signed(div_q) : $signed(div_q);
				end
			end
			ST_SCALE: begin
				sx_mag_q <= sx5[DIV_W+1:2];
				sy_mag_q <= sy5[DIV_W+1:2];
				sx_neg_q <= wq_q[DIV_W-1];
				sy_neg_q <= hq_q[DIV_W-1];
			end
			ST_DIVX: begin
				if (div_done) begin
					stx_q <= step;
				end
			end
			ST_DIVY: begin
				if (div_done) begin
					sty_q  <= step;
					// no peak: position is minus one
					accx_q <= found_q ? '0 : -stx_q;
					accy_q <= found_q ? '0 : -step;
				end
			end
			ST_MUL: begin
				if (posx_q[0]) begin
					accx_q <= accx_q + stx_q;
				end
				if (posy_q[0]) begin
					accy_q <= accy_q + sty_q;
				end
				stx_q  <= stx_q <<< 1;
				sty_q  <= sty_q <<< 1;
				posx_q <= posx_q >> 1;
				posy_q <= posy_q >> 1;
			end
			ST_SUM: begin
				cx_q <= accx_q + centre_x - half_x;
				cy_q <= accy_q + centre_y - half_y;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			peak_x_q     <= sat_x;
			peak_y_q     <= sat_y;
			peak_score_q <= val_q;
			found_out_q  <= found_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_SIZE;
				end
				ST_SIZE: begin
					state_q <= (w256 > prod_q) ? ST_DIVH : ST_SCALE;
				end
				ST_DIVH: begin
					if (div_done) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					state_q <= ST_STX;
				end
				ST_STX: begin
					state_q <= ST_DIVX;
				end
				ST_DIVX: begin
					if (div_done) begin
						state_q <= ST_STY;
					end
				end
				ST_STY: begin
					state_q <= ST_DIVY;
				end
				ST_DIVY: begin
					if (div_done) begin
						cnt_q   <= '0;
						state_q <= found_q ? ST_MUL : ST_SUM;
					end
				end
				ST_MUL: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(CW - 1)) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					// hold until the output register frees up
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign peak_x     = peak_x_q;
	assign peak_y     = peak_y_q;
	assign peak_score = peak_score_q;
	assign found      = found_out_q;

endmodule

[rtl/core/heatmap_keypoint_decoder.sv]
// ----------------------------------------------------------------------------
// heatmap_keypoint_decoder
// Heatmap peak search with mapping of the peak back into the detection box.
//
// Input channel (in_valid / in_stall): one Q3.12 sample word per cycle, raster
// order, map_width*map_height words per keypoint map, each dimension clamped
// to 2..MAX_MAP_DIM. The front takes one word every cycle and raises in_stall
// only while the two-entry peak queue is full.
// Output channel (out_valid / out_stall): one word per map with peak_x, peak_y,
// peak_score and found. The word is held in the output register until taken;
// the sequencer keeps working on the next peak meanwhile.
// From the last sample of a map to its word the sequencer makes up to three
// passes of the shared one-bit-per-cycle divider (aspect fit, x step, y step)
// and a shift-add multiply over the position bits; the aspect-fit division
// runs only when box width*256 exceeds aspect*height, and the shift-add is
// skipped when no peak was found. Sustained: one sample per cycle while every
// map has at least as many samples as the sequencer needs per peak; shorter
// maps are throttled by in_stall. Configuration (cfg_valid / cfg_ready /
// cfg_index / cfg_data): always ready; write only while the block is idle.
// Reset clears the running peak, the raster counters, the queue and the output
// valid flag, and loads the defaults.
module heatmap_keypoint_decoder import hkd_pkg::*; #(
	parameter int MAX_MAP_DIM = MAX_MAP_DIM_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [SAMPLE_W-1:0]   sample_value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [PEAK_W-1:0]     peak_x,
	output logic signed [PEAK_W-1:0]     peak_y,
	output logic signed [SAMPLE_W-1:0]   peak_score,
	output logic                         found
);

	localparam int CW  = $clog2(MAX_MAP_DIM);
	localparam int QDW = SAMPLE_W + 2 * CW;

	box_cfg_t               cfg_q;
	logic [DIM_CFG_W-1:0]   map_width_q;
	logic [DIM_CFG_W-1:0]   map_height_q;
	logic [CW:0]            eff_w;
	logic [CW:0]            eff_h;
	logic                   push;
	logic signed [SAMPLE_W-1:0] push_value;
	logic [CW-1:0]          push_col;
	logic [CW-1:0]          push_row;
	logic [QDW-1:0]         q_dout;
	logic                   q_empty;
	logic                   q_full;
	logic                   pop;

	function automatic logic [CW:0] eff_dim(input logic [DIM_CFG_W-1:0] v);
		if (v < DIM_CFG_W'(2)) begin
			return (CW+1)'(2);
		end else if (32'(v) > 32'(MAX_MAP_DIM)) begin
			return (CW+1)'(MAX_MAP_DIM);
		end
		return (CW+1)'(v);
	endfunction

	assign cfg_ready = 1'b1;
	assign eff_w     = eff_dim(map_width_q);
	assign eff_h     = eff_dim(map_height_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.box_left     <= '0;
			cfg_q.box_top      <= '0;
			cfg_q.box_right    <= BOX_W'(64);
			cfg_q.box_bottom   <= BOX_W'(64);
			cfg_q.aspect       <= ASP_W'(192);
			cfg_q.use_udp      <= 1'b0;
			map_width_q        <= DIM_CFG_W'(48);
			map_height_q       <= DIM_CFG_W'(64);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BOX_LEFT:     cfg_q.box_left     <= cfg_data[BOX_W-1:0];
				REG_BOX_TOP:      cfg_q.box_top      <= cfg_data[BOX_W-1:0];
				REG_BOX_RIGHT:    cfg_q.box_right    <= cfg_data[BOX_W-1:0];
				REG_BOX_BOTTOM:   cfg_q.box_bottom   <= cfg_data[BOX_W-1:0];
				REG_MAP_WIDTH:    map_width_q        <= cfg_data[DIM_CFG_W-1:0];
				REG_MAP_HEIGHT:   map_height_q       <= cfg_data[DIM_CFG_W-1:0];
				REG_ASPECT:       cfg_q.aspect       <= cfg_data[ASP_W-1:0];
				REG_USE_UDP:      cfg_q.use_udp      <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	hkd_front #(.CW(CW)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.eff_w        (eff_w),
		.eff_h        (eff_h),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_value (sample_value),
		.q_full       (q_full),
		.push         (push),
		.push_value   (push_value),
		.push_col     (push_col),
		.push_row     (push_row)
	);

	hkd_queue #(.W(QDW)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    ({push_value, push_col, push_row}),
		.pop    (pop),
		.dout   (q_dout),
		.empty  (q_empty),
		.full   (q_full)
	);

	hkd_back #(.CW(CW)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.eff_w      (eff_w),
		.eff_h      (eff_h),
		.q_empty    (q_empty),
		.q_value    ($signed(q_dout[QDW-1:2*CW])),
		.q_col      (q_dout[2*CW-1:CW]),
		.q_row      (q_dout[CW-1:0]),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.peak_x     (peak_x),
		.peak_y     (peak_y),
		.peak_score (peak_score),
		.found      (found)
	);

endmodule

[rtl/core/hkd_checker.sv]
// ----------------------------------------------------------------------------
// hkd_checker
// Port-level checks on the keypoint decoder, bound to the top level.
// ----------------------------------------------------------------------------
module hkd_checker import hkd_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       cfg_ready,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic signed [PEAK_W-1:0]   peak_x,
	input logic signed [PEAK_W-1:0]   peak_y,
	input logic signed [SAMPLE_W-1:0] peak_score,
	input logic                       found
);

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(peak_x) && $stable(peak_y)
			&& $stable(peak_score) && $stable(found))
		else $error("output word changed while stalled");

	// found flag agrees with the reported peak value
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (found == (!peak_score[SAMPLE_W-1] && (peak_score != '0))))
		else $error("found does not match peak_score");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(!out_stall))
		else $error("output word dropped without being taken");

endmodule

bind heatmap_keypoint_decoder hkd_checker u_hkd_checker (.*);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the heatmap keypoint decoder: streams heatmap sample
// words over many box and map-size settings, predicts each map's peak word and
// compares every output word with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
	import hkd_pkg::*;

	localparam int LIMIT     = 1000000;
	localparam int SETTLE    = 200;
	localparam int HOLD_LEN  = 400;
	localparam int N_ITEMS   = 1600;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic signed [PEAK_W-1:0]   x;
		logic signed [PEAK_W-1:0]   y;
		logic signed [SAMPLE_W-1:0] score;
		logic                       fnd;
	} peak_t;

	typedef struct {
		sample_t v;
		bit      closes;
		sample_t score;
		bit      fnd;
	} row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	sample_t               sample_value;
	logic                  out_valid;
	logic                  out_stall;
	logic signed [PEAK_W-1:0] peak_x;
	logic signed [PEAK_W-1:0] peak_y;
	sample_t               peak_score;
	logic                  found;

	heatmap_keypoint_decoder i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .sample_value(sample_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.peak_x(peak_x), .peak_y(peak_y), .peak_score(peak_score), .found(found)
	);

	// shadow configuration and running peak
	longint box_l, box_t, box_r, box_b, map_w, map_h, aspect, udp;
	longint best_val;
	int     best_col, best_row, col_cnt, row_cnt;

	peak_t  peak_q[$];
	int     errors;
	longint cycles;
	int     n_items;
	bit     steady;
	bit     hold_req;

	function automatic int clamp_dim(longint v);
		if (v < 2) return 2;
		if (v > MAX_MAP_DIM_DEF) return MAX_MAP_DIM_DEF;
		return int'(v);
	endfunction

	function automatic longint box_to_pixel(longint pos, longint centre, longint size, int dim);
		longint div;
		longint c;
		div = udp ? dim - 1 : dim;
		c = pos * (size / div) + centre - size / 2;
		c = c / 65536;
		if (c < -16384) return -16384;
		if (c > 16383) return 16383;
		return c;
	endfunction

	// advance the running peak by one sample, return 1 when a map closes
	function automatic bit track_peak(sample_t s, output peak_t p);
		int     wd, hd;
		longint v, w, h, a, wq, hq, px, py;
		bit     closes;
		wd = clamp_dim(map_w);
		hd = clamp_dim(map_h);
		v = s;
		if ((col_cnt == 0 && row_cnt == 0) || v > best_val) begin
			best_val = v;
			best_col = col_cnt;
			best_row = row_cnt;
		end
		closes = 0;
		if (col_cnt + 1 >= wd) begin
			col_cnt = 0;
			if (row_cnt + 1 >= hd) begin
				row_cnt = 0;
				closes = 1;
			end else begin
				row_cnt++;
			end
		end else begin
			col_cnt++;
		end
		p = '0;
		if (!closes) return 0;
		a = aspect ? aspect : 1;
		w = box_r - box_l;
		h = box_b - box_t;
		if (w * 256 > a * h) begin
			wq = w * 65536;
			hq = (w * 16777216) / a;
		end else if (w * 256 < a * h) begin
			hq = h * 65536;
			wq = h * a * 256;
		end else begin
			wq = w * 65536;
			hq = h * 65536;
		end
		px = best_val > 0 ? best_col : -1;
		py = best_val > 0 ? best_row : -1;
		p.x = PEAK_W'(box_to_pixel(px, (box_l + box_r) * 32768, (wq * 5) / 4, wd));
		p.y = PEAK_W'(box_to_pixel(py, (box_t + box_b) * 32768, (hq * 5) / 4, hd));
		p.score = SAMPLE_W'(best_val);
		p.fnd = best_val > 0;
		return 1;
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// output side: random stall, with one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 0;
				out_stall <= 1;
				repeat (HOLD_LEN) @(posedge clk);
			end
			out_stall <= (!steady && $urandom_range(99) < 31);
		end
	end

	always @(posedge clk) begin
		peak_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (peak_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected word x=%0d y=%0d score=%0d found=%0b",
						peak_x, peak_y, peak_score, found);
			end else begin
				e = peak_q.pop_front();
				if (peak_x !== e.x || peak_y !== e.y || peak_score !== e.score ||
						found !== e.fnd) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp x=%0d y=%0d score=%0d found=%0b, got x=%0d y=%0d score=%0d found=%0b",
							e.x, e.y, e.score, e.fnd, peak_x, peak_y, peak_score, found);
				end
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint val);
		logic [CFG_DATA_W-1:0] d;
		d = CFG_DATA_W'($urandom);
		case (idx)
			REG_BOX_LEFT, REG_BOX_TOP, REG_BOX_RIGHT, REG_BOX_BOTTOM:
				d[BOX_W-1:0] = BOX_W'(val);
			REG_MAP_WIDTH, REG_MAP_HEIGHT: d[DIM_CFG_W-1:0] = DIM_CFG_W'(val);
			REG_ASPECT: d = CFG_DATA_W'(val);
			default: d[0] = val[0];
		endcase
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		case (idx)
			REG_BOX_LEFT:     box_l = d[11:0];
			REG_BOX_TOP:      box_t = d[11:0];
			REG_BOX_RIGHT:    box_r = d[11:0];
			REG_BOX_BOTTOM:   box_b = d[11:0];
			REG_MAP_WIDTH:    map_w = d[8:0];
			REG_MAP_HEIGHT:   map_h = d[8:0];
			REG_ASPECT:       aspect = d;
			default:          udp = d[0];
		endcase
	endtask

	task automatic setup(longint l, longint t, longint r, longint b, longint w, longint h,
			longint a, longint u);
		write_reg(REG_BOX_LEFT, l);
		write_reg(REG_BOX_TOP, t);
		write_reg(REG_BOX_RIGHT, r);
		write_reg(REG_BOX_BOTTOM, b);
		write_reg(REG_MAP_WIDTH, w);
		write_reg(REG_MAP_HEIGHT, h);
		write_reg(REG_ASPECT, a);
		write_reg(REG_USE_UDP, u);
	endtask

	// hold until every pending word has drained, then let the divider settle
	task automatic drain();
		while (peak_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic put_sample(sample_t v);
		peak_t p;
		in_valid <= 1;
		sample_value <= v;
		do @(posedge clk); while (in_stall);
		n_items++;
		if (track_peak(v, p)) peak_q = {peak_q, p};
		if (!steady && $urandom_range(99) < 18) begin
			in_valid <= 0;
			sample_value <= SAMPLE_W'($urandom);
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	function automatic longint pick_coord();
		case ($urandom_range(5))
			0: return 0;
			1: return 4095;
			default: return $urandom_range(4095);
		endcase
	endfunction

	function automatic sample_t pick_sample(int mode);
		case (mode)
			0: return SAMPLE_W'($urandom);
			1: return SAMPLE_W'($urandom_range(8) - 4);
			2: return SAMPLE_W'(-$signed({1'b0, 15'($urandom)}) - 1);
			default: return SAMPLE_W'($urandom_range(3) * 16'sh1000);
		endcase
	endfunction

	row_t dir_rows[20] = '{
		'{16'sd0, 0, 0, 0}, '{16'sd0, 0, 0, 0}, '{16'sd0, 0, 0, 0}, '{16'sd0, 1, 0, 0},
		'{16'sd32767, 0, 0, 0}, '{16'sd32767, 0, 0, 0}, '{-16'sd32768, 0, 0, 0},
		'{16'sd5, 1, 16'sd32767, 1},
		'{-16'sd32768, 0, 0, 0}, '{-16'sd32768, 0, 0, 0}, '{-16'sd32768, 0, 0, 0},
		'{-16'sd32768, 1, -16'sd32768, 0},
		'{-16'sd1, 0, 0, 0}, '{16'sd1, 0, 0, 0}, '{16'sd1, 0, 0, 0}, '{-16'sd1, 1, 16'sd1, 1},
		'{16'sh5555, 0, 0, 0}, '{-16'sd21846, 0, 0, 0}, '{16'sh2aaa, 0, 0, 0},
		'{16'sd1, 1, 16'sh5555, 1}
	};

	initial begin
		int     phase;
		int     mode;
		longint w, h, l, t, r, b, a;
		arst_n = 0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 0;
		sample_value = '0;
		out_stall = 0;
		cycles = 0;
		errors = 0;
		n_items = 0;
		steady = 0;
		hold_req = 0;
		box_l = 0; box_t = 0; box_r = 64; box_b = 64;
		map_w = 48; map_h = 64; aspect = 192; udp = 0;
		best_val = 0; best_col = 0; best_row = 0; col_cnt = 0; row_cnt = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// directed: 2x2 maps, zero map, ties, all-minimum, peak in the first sample
		setup(0, 0, 64, 64, 2, 2, 192, 0);
		foreach (dir_rows[i]) begin
			put_sample(dir_rows[i].v);
			if (dir_rows[i].closes && (peak_q.size() == 0 ||
					peak_q[$].score !== dir_rows[i].score ||
					peak_q[$].fnd !== dir_rows[i].fnd)) begin
				errors++;
				$display("directed row %0d: predicted score/found differ from table", i);
			end
		end
		in_valid <= 0;
		drain();

		// extremes of the box, aspect and dimension saturation
		setup(4095, 4095, 0, 0, 1, 0, 0, 1);
		repeat (8) put_sample(pick_sample(0));
		in_valid <= 0;
		drain();
		setup(0, 0, 4095, 4095, 511, 2, 65535, 0);
		repeat (512) put_sample(pick_sample(0));
		in_valid <= 0;
		drain();
		setup(0, 4095, 4095, 0, 2, 256, 1, 1);
		repeat (512) put_sample(pick_sample(1));
		in_valid <= 0;
		drain();

		phase = 0;
		while (n_items < N_ITEMS) begin
			phase++;
			steady = (phase >= 2 && phase < 5);
			case ($urandom_range(19))
				0: begin w = $urandom_range(1); h = $urandom_range(2, 5); end
				1: begin w = $urandom_range(256, 511); h = 2; end
				2: begin w = 2; h = $urandom_range(257, 511); end
				default: begin w = $urandom_range(2, 6); h = $urandom_range(2, 6); end
			endcase
			// small maps while the receiver holds off, so the block fills up
			if (phase == 1) begin w = 2; h = 2; end
			l = pick_coord(); t = pick_coord(); r = pick_coord(); b = pick_coord();
			if ($urandom_range(4) != 0) begin
				if (l > r) begin a = l; l = r; r = a; end
				if (t > b) begin a = t; t = b; b = a; end
			end
			case ($urandom_range(7))
				0: a = 0;
				1: a = 1;
				2: a = 65535;
				default: a = $urandom_range(128, 512);
			endcase
			setup(l, t, r, b, w, h, a, $urandom_range(1));
			if (phase == 1) hold_req = 1;
			mode = $urandom_range(3);
			begin
				int cnt;
				cnt = clamp_dim(w) * clamp_dim(h);
				cnt = cnt > 64 ? cnt : cnt * $urandom_range(1, 6);
				if ($urandom_range(3) == 0) cnt += $urandom_range(1, 5);
				if (phase == 1) cnt = 200;
				repeat (cnt) put_sample(pick_sample($urandom_range(4) == 0 ? 0 : mode));
			end
			in_valid <= 0;
			drain();
		end
		steady = 0;

		if (errors == 0 && peak_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[files.f]
rtl/core/hkd_pkg.sv
rtl/core/hkd_front.sv
rtl/core/hkd_queue.sv
rtl/core/hkd_div.sv
rtl/core/hkd_back.sv
rtl/core/heatmap_keypoint_decoder.sv
rtl/core/hkd_checker.sv
tb/sv/testbench.sv
